[hw/rtl/voxr_pkg.sv]
package voxr_pkg;

   typedef enum logic [7:0] {
      ST_CLEAR = 8'b0000_0001,
      ST_IDLE  = 8'b0000_0010,
      ST_SETUP = 8'b0000_0100,
      ST_DIVW  = 8'b0000_1000,
      ST_WALK  = 8'b0001_0000,
      ST_TEST  = 8'b0010_0000,
      ST_STEP  = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_BREAK = 2'd1;
   localparam logic [1:0] OP_PLACE = 2'd2;

   localparam logic REG_PLACED_TYPE = 1'b0;

   localparam logic [31:0] DIST_MAX = 32'hFFFF_FFFF;
   localparam int          DIV_BITS = 31;

   // packed from the top down so that hit lands in bit 0
   typedef struct packed {
      logic       edited;
      logic [1:0] normal_z;
      logic [1:0] normal_y;
      logic [1:0] normal_x;
      logic [3:0] hit_z;
      logic [3:0] hit_y;
      logic [3:0] hit_x;
      logic       hit;
   } result_type;

   typedef struct packed {
      logic                start;
      logic [DIV_BITS-1:0] num;
      logic [15:0]         den;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [DIV_BITS-1:0] quo;
   } div_rsp_type;

endpackage

[hw/rtl/voxr_ram.sv]
module voxr_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[hw/rtl/voxr_div.sv]
module voxr_div import voxr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [DIV_BITS-1:0] q_ff, q_in;
   logic [15:0]         rem_ff, rem_in;
   logic [4:0]          cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [16:0]         shifted;
   logic                fits;

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, q_ff[DIV_BITS-1]};
      fits    = shifted >= {1'b0, req.den};
      if (req.start) begin
         q_in    = req.num;
         rem_in  = '0;
         cnt_in  = 5'(DIV_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // one quotient bit per cycle, remainder stays below the divisor
         rem_in = fits ? 16'(shifted - {1'b0, req.den}) : shifted[15:0];
         q_in   = {q_ff[DIV_BITS-2:0], fits};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = q_ff;

endmodule

[hw/rtl/voxel_ray_traversal_edit_top.sv]
// channel | dir | handshake            | payload
// req     | in  | req_tvalid/tready    | tuser: opcode; tdata: pos, dir, max_distance, block_word
// rsp     | out | rsp_tvalid/tready    | tdata: hit, hit_x/y/z, normal_x/y/z, edited
// csr     | in  | APB psel/penable     | placed_block_type at byte address 0
//
// A write item goes through ST_DONE back to ST_IDLE. A cast runs up to six reciprocal
// divisions on the one shared divider (a boundary distance and an increment per moving
// axis), then steps voxel by voxel through ST_WALK, ST_TEST (skipped outside the grid)
// and ST_STEP, using the registered read of the voxel memory. After reset a clearing
// pass writes air to all GRID_DIM**3 entries, one per cycle, with req_tready low. A
// finished result waits in the output register while the next item is taken.
module voxel_ray_traversal_edit_top import voxr_pkg::*; #(
   parameter int GRID_DIM = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,   // opcode
   // pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, max_distance, block_word
   input  logic [135:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // hit, hit_x, hit_y, hit_z, normal_x, normal_y, normal_z, edited, zero pad
   output logic [23:0]  rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int DEPTH = GRID_DIM * GRID_DIM * GRID_DIM;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(GRID_DIM);

   function automatic logic inside_grid(input logic [9:0] c0, input logic [9:0] c1,
                                        input logic [9:0] c2);
      inside_grid = !c0[9] && (c0 < 10'(GRID_DIM)) && !c1[9] && (c1 < 10'(GRID_DIM))
                    && !c2[9] && (c2 < 10'(GRID_DIM));
   endfunction

   function automatic logic [AW-1:0] grid_addr(input logic [9:0] c0, input logic [9:0] c1,
                                               input logic [9:0] c2);
      grid_addr = AW'(c0[CW-1:0]) + AW'(GRID_DIM) * AW'(c1[CW-1:0])
                  + AW'(GRID_DIM * GRID_DIM) * AW'(c2[CW-1:0]);
   endfunction

   function automatic logic [9:0] int_part(input logic [15:0] p);
      int_part = {{2{p[15]}}, p[15:8]};
   endfunction

   state_type   state_ff, state_in;
   logic [1:0]  ax_ff, ax_in;
   logic        ph_ff, ph_in;
   logic [1:0]  op_ff, op_in;
   logic [15:0] pos_ff [3];
   logic [15:0] pos_in [3];
   logic [15:0] dir_ff [3];
   logic [15:0] dir_in [3];
   logic [15:0] lim_ff, lim_in;
   logic [15:0] tex_ff, tex_in;
   logic [31:0] t_ff, t_in;
   logic [9:0]  cur_ff [3];
   logic [9:0]  cur_in [3];
   logic [31:0] bd_ff [3];
   logic [31:0] bd_in [3];
   logic [31:0] inc_ff [3];
   logic [31:0] inc_in [3];
   logic [1:0]  sgn_ff [3];
   logic [1:0]  sgn_in [3];
   logic [1:0]  ls_ff [3];
   logic [1:0]  ls_in [3];
   result_type  res_ff, res_in;
   result_type  rsp_data_ff, rsp_data_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  ptype_ff, ptype_in;
   logic [AW-1:0] clr_ff, clr_in;

   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [23:0]   mem_wdata, mem_rdata;
   div_req_type   div_req;
   div_rsp_type   div_rsp;

   logic [9:0]  wr_c [3];
   logic [1:0]  nrm [3];
   logic [9:0]  tgt [3];
   logic [1:0]  sel;
   logic        any;
   logic [32:0] sum;
   logic [8:0]  frac;
   logic [15:0] mag;
   logic [AW-1:0] cur_addr;
   logic        cur_inside;
   logic        accept;

   voxr_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   voxr_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_data_ff};
   assign csr_pready = 1'b1;
   assign csr_prdata = {24'b0, ptype_ff};
   assign cur_addr   = grid_addr(cur_ff[0], cur_ff[1], cur_ff[2]);
   assign cur_inside = inside_grid(cur_ff[0], cur_ff[1], cur_ff[2]);
   assign mem_raddr  = cur_addr;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         wr_c[a] = int_part(req_tdata[16*a +: 16]);
         nrm[a]  = 2'(-ls_ff[a]);
         tgt[a]  = cur_ff[a] + {{8{nrm[a][1]}}, nrm[a]};
      end
      // least boundary distance among moving axes, lowest axis on a tie
      sel = 2'd0;
      any = 1'b0;
      for (int a = 0; a < 3; a++) begin
         if (sgn_ff[a] != 2'b00 && (!any || bd_ff[a] < bd_ff[sel])) begin
            sel = 2'(a);
            any = 1'b1;
         end
      end
      sum  = {1'b0, bd_ff[sel]} + {1'b0, inc_ff[sel]};
      mag  = dir_ff[ax_ff][15] ? 16'(-dir_ff[ax_ff]) : dir_ff[ax_ff];
      frac = dir_ff[ax_ff][15] ? {1'b0, pos_ff[ax_ff][7:0]}
                               : 9'd256 - {1'b0, pos_ff[ax_ff][7:0]};
   end

   always_comb begin
      state_in     = state_ff;
      ax_in        = ax_ff;
      ph_in        = ph_ff;
      op_in        = op_ff;
      pos_in       = pos_ff;
      dir_in       = dir_ff;
      lim_in       = lim_ff;
      tex_in       = tex_ff;
      t_in         = t_ff;
      cur_in       = cur_ff;
      bd_in        = bd_ff;
      inc_in       = inc_ff;
      sgn_in       = sgn_ff;
      ls_in        = ls_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      ptype_in     = ptype_ff;
      clr_in       = clr_ff;
      mem_we       = 1'b0;
      mem_waddr    = cur_addr;
      mem_wdata    = '0;
      div_req      = '{start: 1'b0, num: '0, den: mag};

      if (csr_psel && csr_penable && csr_pwrite && csr_pready
          && csr_paddr[2] == REG_PLACED_TYPE) begin
         ptype_in = csr_pwdata[7:0];
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               op_in  = req_tuser;
               res_in = '0;
               for (int a = 0; a < 3; a++) begin
                  pos_in[a] = req_tdata[16*a +: 16];
                  dir_in[a] = req_tdata[48 + 16*a +: 16];
               end
               lim_in = req_tdata[111:96];
               tex_in = req_tdata[127:112];
               ax_in  = 2'd0;
               ph_in  = 1'b0;
               if (req_tuser == OP_BREAK || req_tuser == OP_PLACE) begin
                  state_in = ST_SETUP;
               end else begin
                  state_in = ST_DONE;
               end
               if (req_tuser == OP_WRITE && inside_grid(wr_c[0], wr_c[1], wr_c[2])) begin
                  mem_we    = 1'b1;
                  mem_waddr = grid_addr(wr_c[0], wr_c[1], wr_c[2]);
                  mem_wdata = req_tdata[135:112];
               end
            end
         end
         ST_SETUP: begin
            if (ax_ff == 2'd3) begin
               t_in     = '0;
               state_in = ST_WALK;
            end else begin
               cur_in[ax_ff] = int_part(pos_ff[ax_ff]);
               ls_in[ax_ff]  = 2'b00;
               if (dir_ff[ax_ff] == 16'd0) begin
                  sgn_in[ax_ff] = 2'b00;
                  bd_in[ax_ff]  = DIST_MAX;
                  inc_in[ax_ff] = '0;
                  ax_in         = ax_ff + 2'd1;
               end else begin
                  sgn_in[ax_ff] = dir_ff[ax_ff][15] ? 2'b11 : 2'b01;
                  div_req.start = 1'b1;
                  div_req.num   = ph_ff ? DIV_BITS'(1 << 30) : {frac, 22'b0};
                  state_in      = ST_DIVW;
               end
            end
         end
         ST_DIVW: begin
            if (div_rsp.done) begin
               if (!ph_ff) begin
                  bd_in[ax_ff] = {1'b0, div_rsp.quo};
                  ph_in        = 1'b1;
               end else begin
                  inc_in[ax_ff] = {1'b0, div_rsp.quo};
                  ph_in         = 1'b0;
                  ax_in         = ax_ff + 2'd1;
               end
               state_in = ST_SETUP;
            end
         end
         ST_WALK: begin
            if (t_ff >= {8'b0, lim_ff, 8'b0}) begin
               state_in = ST_DONE;
            end else if (cur_inside) begin
               state_in = ST_TEST;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_TEST: begin
            if (mem_rdata[23:16] != 8'd0) begin
               res_in.hit      = 1'b1;
               res_in.hit_x    = cur_ff[0][3:0];
               res_in.hit_y    = cur_ff[1][3:0];
               res_in.hit_z    = cur_ff[2][3:0];
               res_in.normal_x = nrm[0];
               res_in.normal_y = nrm[1];
               res_in.normal_z = nrm[2];
               if (op_ff == OP_BREAK) begin
                  mem_we        = 1'b1;
                  res_in.edited = 1'b1;
               end else if (inside_grid(tgt[0], tgt[1], tgt[2])) begin
                  mem_we        = 1'b1;
                  mem_waddr     = grid_addr(tgt[0], tgt[1], tgt[2]);
                  mem_wdata     = {ptype_ff, tex_ff};
                  res_in.edited = 1'b1;
               end
               state_in = ST_DONE;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (!any) begin
               state_in = ST_DONE;
            end else begin
               t_in       = bd_ff[sel];
               bd_in[sel] = sum[32] ? DIST_MAX : sum[31:0];
               for (int a = 0; a < 3; a++) begin
                  ls_in[a] = 2'b00;
               end
               ls_in[sel]  = sgn_ff[sel];
               cur_in[sel] = cur_ff[sel] + {{8{sgn_ff[sel][1]}}, sgn_ff[sel]};
               state_in    = ST_WALK;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         ptype_ff     <= 8'd1;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         ptype_ff     <= ptype_in;
      end
      ax_ff       <= ax_in;
      ph_ff       <= ph_in;
      op_ff       <= op_in;
      pos_ff      <= pos_in;
      dir_ff      <= dir_in;
      lim_ff      <= lim_in;
      tex_ff      <= tex_in;
      t_ff        <= t_in;
      cur_ff      <= cur_in;
      bd_ff       <= bd_in;
      inc_ff      <= inc_in;
      sgn_ff      <= sgn_in;
      ls_ff       <= ls_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

[hw/rtl/voxr_chk.sv]
module voxr_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result item dropped while stalled");

   a_miss_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[19:1] == 19'd0)
      else $error("miss item carries nonzero fields");

   a_one_normal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $countones({rsp_tdata[14:13] != 2'b00, rsp_tdata[16:15] != 2'b00,
                                 rsp_tdata[18:17] != 2'b00}) <= 1)
      else $error("normal has more than one nonzero axis");

   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_tready && !rsp_tvalid)
      else $error("item taken during clearing pass");

endmodule

bind voxel_ray_traversal_edit_top voxr_chk u_voxr_chk (.*);

[verif/testbench.sv]
module testbench;
   import voxr_pkg::*;

   typedef struct {
      logic [1:0]  opcode;
      logic [15:0] pos_x, pos_y, pos_z;
      logic [15:0] dir_x, dir_y, dir_z;
      logic [15:0] max_dist;
      logic [23:0] block_word;
   } ray_item_type;

   localparam int GRID = 16;
   localparam int WATCHDOG_LIMIT = 200000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [1:0]   req_tuser = '0;
   logic [135:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [23:0]  rsp_tdata;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [2:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   voxel_ray_traversal_edit_top #(.GRID_DIM(GRID)) dut (.*);

   ray_item_type pending_items[$];
   result_type   expected_hits[$];
   logic [23:0]  voxel_mem[GRID*GRID*GRID];
   logic [7:0]   placed_type = 8'd1;
   int           err_count = 0;
   bit           idle_on = 1'b1;
   bit           hold_req = 1'b0;
   int           hold_left = 0;
   int           req_gap = 0;
   int           rsp_stall = 0;
   int           quiet_cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic bit in_grid(int c[3]);
      return c[0] >= 0 && c[0] < GRID && c[1] >= 0 && c[1] < GRID && c[2] >= 0 && c[2] < GRID;
   endfunction

   function automatic int voxel_index(int c[3]);
      return c[0] + GRID * (c[1] + GRID * c[2]);
   endfunction

   function automatic result_type trace_ray(ray_item_type it);
      int          pos[3], dr[3], cur[3], stp[3], last[3], tgt[3];
      logic [31:0] bnd[3], inc[3];
      logic [31:0] num, mag, t, lim;
      logic [32:0] sum;
      logic [9:0]  w10;
      int          ax, frac;
      result_type  r;
      r = '0;
      pos[0] = $signed(it.pos_x); pos[1] = $signed(it.pos_y); pos[2] = $signed(it.pos_z);
      dr[0] = $signed(it.dir_x);  dr[1] = $signed(it.dir_y);  dr[2] = $signed(it.dir_z);
      if (it.opcode == OP_WRITE) begin
         for (int a = 0; a < 3; a++) cur[a] = pos[a] >>> 8;
         if (in_grid(cur)) voxel_mem[voxel_index(cur)] = it.block_word;
         return r;
      end
      if (it.opcode != OP_BREAK && it.opcode != OP_PLACE) return r;
      for (int a = 0; a < 3; a++) begin
         cur[a] = pos[a] >>> 8;
         last[a] = 0;
         if (dr[a] == 0) begin
            stp[a] = 0; bnd[a] = DIST_MAX; inc[a] = 0;
         end else begin
            if (dr[a] > 0) begin
               stp[a] = 1; mag = 32'(dr[a]); frac = (cur[a] + 1) * 256 - pos[a];
            end else begin
               stp[a] = -1; mag = 32'(-dr[a]); frac = pos[a] - cur[a] * 256;
            end
            num = 32'(frac) << 22;
            bnd[a] = num / mag;
            inc[a] = 32'h4000_0000 / mag;
         end
      end
      lim = {8'd0, it.max_dist, 8'd0};
      t = '0;
      while (t < lim) begin
         if (in_grid(cur) && voxel_mem[voxel_index(cur)][23:16] != 8'd0) begin
            r.hit = 1'b1;
            r.hit_x = 4'(cur[0]); r.hit_y = 4'(cur[1]); r.hit_z = 4'(cur[2]);
            r.normal_x = 2'(-last[0]); r.normal_y = 2'(-last[1]); r.normal_z = 2'(-last[2]);
            for (int a = 0; a < 3; a++) tgt[a] = cur[a] - last[a];
            if (it.opcode == OP_BREAK) begin
               voxel_mem[voxel_index(cur)] = '0;
               r.edited = 1'b1;
            end else if (in_grid(tgt)) begin
               voxel_mem[voxel_index(tgt)] = {placed_type, it.block_word[15:0]};
               r.edited = 1'b1;
            end
            return r;
         end
         ax = -1;
         for (int a = 0; a < 3; a++)
            if (stp[a] != 0 && (ax < 0 || bnd[a] < bnd[ax])) ax = a;
         if (ax < 0) break;
         t = bnd[ax];
         sum = {1'b0, bnd[ax]} + {1'b0, inc[ax]};
         bnd[ax] = sum[32] ? DIST_MAX : sum[31:0];
         for (int a = 0; a < 3; a++) last[a] = 0;
         last[ax] = stp[ax];
         w10 = 10'(cur[ax] + stp[ax]);
         cur[ax] = int'($signed(w10));
      end
      return r;
   endfunction

   function automatic ray_item_type mk(logic [1:0] op, int px, int py, int pz, int dx, int dy,
                                       int dz, int md, int bw);
      ray_item_type it;
      it.opcode = op;
      it.pos_x = 16'(px); it.pos_y = 16'(py); it.pos_z = 16'(pz);
      it.dir_x = 16'(dx); it.dir_y = 16'(dy); it.dir_z = 16'(dz);
      it.max_dist = 16'(md); it.block_word = 24'(bw);
      return it;
   endfunction

   function automatic logic [15:0] rand_dir();
      int k;
      k = $urandom_range(0, 9);
      if (k < 2) return 16'd0;
      if (k < 3) return 16'($signed($urandom_range(0, 64)) - 32);
      return 16'($urandom);
   endfunction

   function automatic ray_item_type rand_item();
      ray_item_type it;
      int k;
      k = $urandom_range(0, 99);
      if (k < 40) it.opcode = OP_WRITE;
      else if (k < 68) it.opcode = OP_BREAK;
      else if (k < 96) it.opcode = OP_PLACE;
      else it.opcode = 2'd3;
      if ($urandom_range(0, 9) < 8) begin
         it.pos_x = 16'($urandom_range(0, 4095));
         it.pos_y = 16'($urandom_range(0, 4095));
         it.pos_z = 16'($urandom_range(0, 4095));
      end else begin
         it.pos_x = 16'($urandom); it.pos_y = 16'($urandom); it.pos_z = 16'($urandom);
      end
      it.dir_x = rand_dir(); it.dir_y = rand_dir(); it.dir_z = rand_dir();
      k = $urandom_range(0, 19);
      it.max_dist = (k == 0) ? 16'($urandom) : 16'($urandom_range(0, 8191));
      it.block_word = 24'($urandom);
      if ($urandom_range(0, 9) == 0) it.block_word[23:16] = 8'd0;
      return it;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      err_count++;
   endtask

   // driver
   always @(posedge clock) begin
      logic nv;
      ray_item_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            it.opcode = req_tuser;
            {it.block_word, it.max_dist, it.dir_z, it.dir_y, it.dir_x,
             it.pos_z, it.pos_y, it.pos_x} = req_tdata;
            expected_hits.push_back(trace_ray(it));
         end
         if (!(req_tvalid && !req_tready)) begin
            nv = 1'b0;
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_items.size() > 0) begin
               it = pending_items.pop_front();
               req_tuser <= it.opcode;
               req_tdata <= {it.block_word, it.max_dist, it.dir_z, it.dir_y, it.dir_x,
                             it.pos_z, it.pos_y, it.pos_x};
               nv = 1'b1;
               if (idle_on && $urandom_range(0, 7) == 0) req_gap = $urandom_range(1, 8);
            end
            req_tvalid <= nv;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      logic nr;
      result_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[19:0]);
            if (expected_hits.size() == 0) begin
               report_mismatch("result with nothing expected", int'(rsp_tdata), 0);
            end else begin
               want = expected_hits.pop_front();
               if (got.hit != want.hit) report_mismatch("hit", got.hit, want.hit);
               if (got.hit_x != want.hit_x) report_mismatch("hit_x", got.hit_x, want.hit_x);
               if (got.hit_y != want.hit_y) report_mismatch("hit_y", got.hit_y, want.hit_y);
               if (got.hit_z != want.hit_z) report_mismatch("hit_z", got.hit_z, want.hit_z);
               if (got.normal_x != want.normal_x)
                  report_mismatch("normal_x", got.normal_x, want.normal_x);
               if (got.normal_y != want.normal_y)
                  report_mismatch("normal_y", got.normal_y, want.normal_y);
               if (got.normal_z != want.normal_z)
                  report_mismatch("normal_z", got.normal_z, want.normal_z);
               if (got.edited != want.edited) report_mismatch("edited", got.edited, want.edited);
            end
         end
         if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 400;
         end
         nr = 1'b0;
         if (hold_left > 0) hold_left--;
         else if (rsp_stall > 0) rsp_stall--;
         else begin
            nr = 1'b1;
            if (idle_on && $urandom_range(0, 5) == 0) rsp_stall = $urandom_range(1, 8);
         end
         rsp_tready <= nr;
      end
   end

   // watchdog: any accepted item or result counts as progress
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   task automatic drain();
      @(negedge clock);
      while (pending_items.size() > 0 || req_tvalid || expected_hits.size() > 0)
         @(negedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_placed_type(logic [7:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {REG_PLACED_TYPE, 2'b00};
      csr_pwdata <= {24'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      placed_type = value;
   endtask

   task automatic random_items(int n);
      for (int i = 0; i < n; i++) pending_items.push_back(rand_item());
   endtask

   initial begin
      for (int i = 0; i < GRID*GRID*GRID; i++) voxel_mem[i] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // corners, outside writes and extreme positions
      pending_items.push_back(mk(OP_WRITE, 0, 0, 0, 0, 0, 0, 0, 24'hFFFFFF));
      pending_items.push_back(mk(OP_WRITE, 15*256+255, 15*256, 15*256, 0, 0, 0, 0, 24'h0A1234));
      pending_items.push_back(mk(OP_WRITE, -1, 5*256, 5*256, 0, 0, 0, 0, 24'h050505));
      pending_items.push_back(mk(OP_WRITE, 16*256, 5*256, 5*256, 0, 0, 0, 0, 24'h050505));
      pending_items.push_back(mk(OP_WRITE, -32768, 32767, -32768, -32768, 32767, 0, 65535, 24'h0));
      pending_items.push_back(mk(OP_WRITE, 3*256, 3*256, 3*256, 0, 0, 0, 0, 24'h07BEEF));
      pending_items.push_back(mk(OP_WRITE, 0, 8*256, 8*256, 0, 0, 0, 0, 24'h020000));
      // start voxel hit with no direction: zero normal, place onto itself
      pending_items.push_back(mk(OP_PLACE, 3*256+128, 3*256+128, 3*256+128, 0, 0, 0, 10, 24'h00C0DE));
      // all-zero direction in air
      pending_items.push_back(mk(OP_BREAK, 9*256, 9*256, 9*256, 0, 0, 0, 65535, 0));
      // place target falls outside the store
      pending_items.push_back(mk(OP_PLACE, -2*256+100, 8*256+128, 8*256+128, 16384, 0, 0, 4096, 24'h0000AA));
      // zero max distance
      pending_items.push_back(mk(OP_BREAK, 3*256, 3*256, 3*256, 16384, 0, 0, 0, 0));
      // diagonal with tied boundaries toward a corner voxel
      pending_items.push_back(mk(OP_BREAK, 128, 128, 128, 16384, 16384, 16384, 65535, 0));
      pending_items.push_back(mk(OP_BREAK, 15*256+128, 15*256+128, 15*256+128, -16384, -16384, -16384, 65535, 0));
      pending_items.push_back(mk(OP_PLACE, 20*256, 15*256+128, 15*256+128, -32768, 0, 0, 65535, 24'h00FFFF));
      pending_items.push_back(mk(OP_BREAK, 8*256, 8*256, 8*256, 32767, -1, 1, 65535, 0));
      pending_items.push_back(mk(OP_PLACE, 32767, 32767, 32767, -32768, -32768, -32768, 65535, 0));
      pending_items.push_back(mk(2'd3, 1, 2, 3, 4, 5, 6, 7, 24'h123456));
      pending_items.push_back(mk(OP_BREAK, 3*256, 3*256, 3*256, 0, 0, 0, 1, 0));
      drain();

      write_placed_type(8'd255);
      hold_req = 1'b1;
      random_items(500);
      drain();
      write_placed_type(8'd0);
      random_items(500);
      drain();
      write_placed_type(8'($urandom_range(1, 254)));
      random_items(500);
      drain();
      idle_on = 1'b0;
      random_items(500);
      drain();

      if (err_count == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule

[voxel_ray_traversal_edit_top.f]
hw/rtl/voxr_pkg.sv
hw/rtl/voxr_ram.sv
hw/rtl/voxr_div.sv
hw/rtl/voxel_ray_traversal_edit_top.sv
hw/rtl/voxr_chk.sv
verif/testbench.sv
